@@ rtl/core/qrfk_pkg.sv @@
// qrfk_pkg: shared types and codes for the queue with front reversal
// no dependencies; imported by queue_reverse_first_k

package qrfk_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;

    // operation codes of a request
    localparam t_kind KIND_ENQ = 2'd0;
    localparam t_kind KIND_DEQ = 2'd1;
    localparam t_kind KIND_REV = 2'd2;

    // status codes of a result
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_TOO_LONG = 2'd3;

    // fixed port field widths
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 5;
    localparam int COUNT_W = 5;

endpackage

@@ rtl/core/qrfk_ram.sv @@
// qrfk_ram: generic single write port, single read port ram
// registered read data; no package dependencies

module qrfk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/queue_reverse_first_k.sv @@
// queue_reverse_first_k: bounded ring queue with enqueue, dequeue and
// reversal of the first k entries; uses qrfk_pkg and qrfk_ram
// enqueue, dequeue and no-op pass through S_EXEC, S_RD and S_CAP after acceptance;
// a reverse of k entries adds floor(k/2) swaps, each through S_RA, S_RB, S_WA, S_WB,
// set by the single read and single write port of the ring ram
// a new request is taken only in S_IDLE, once the last result is loaded
// reset (synchronous, active low) empties the queue; ram contents are kept

module queue_reverse_first_k
    import qrfk_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [LEN_W-1:0]           i_reverse_length,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic                       o_front_valid,
    output logic signed [VALUE_W-1:0]  o_front_value,
    output logic [COUNT_W-1:0]         o_entry_count
);

    // ring index width, count width and width for comparing k to the count
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > LEN_W) ? CW : LEN_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] S_EXEC = 3'd1;  // check and update pointers
    localparam logic [2:0] S_RA   = 3'd2;  // read low entry of a swap
    localparam logic [2:0] S_RB   = 3'd3;  // read high entry, keep low one
    localparam logic [2:0] S_WA   = 3'd4;  // high word into low slot
    localparam logic [2:0] S_WB   = 3'd5;  // low word into high slot
    localparam logic [2:0] S_RD   = 3'd6;  // read the front entry
    localparam logic [2:0] S_CAP  = 3'd7;  // load the result register

    logic [2:0]            r_state, n_state;
    t_kind                 r_kind, n_kind;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [LEN_W-1:0]      r_k, n_k;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;
    t_status               r_status, n_status;

    // result register, parts the sequencer from the result channel
    logic                  r_ov, n_ov;
    t_status               r_o_status, n_o_status;
    logic                  r_o_fv, n_o_fv;
    logic [VALUE_W-1:0]    r_o_fval, n_o_fval;
    logic [COUNT_W-1:0]    r_o_count, n_o_count;

    // ram ports
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  in_acc;
    logic                  out_acc;
    logic [DATA_WIDTH-1:0] word_in;
    logic [VALUE_W-1:0]    front_ext;
    logic [COUNT_W-1:0]    count_port;
    logic [AW-1:0]         addr_lo;
    logic [AW-1:0]         addr_hi;
    logic [KW-1:0]         k_ext;
    logic [KW-1:0]         count_ext;

    // next ring index with wrap
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    // head plus offset, modulo depth by one compare and subtract
    function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] head,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_ov && i_out_ready;

    assign addr_lo   = ring_at(r_head, r_lo);
    assign addr_hi   = ring_at(r_head, r_hi);
    assign k_ext     = KW'(r_k);
    assign count_ext = KW'(r_count);

    // input word kept in DATA_WIDTH bits, sign extended above 32
    // front word sign extended from DATA_WIDTH bits, cut to 32
    // count shown in the 5 bit field
    always_comb begin
        for (int i = 0; i < DATA_WIDTH; i++) begin
            word_in[i] = (i < VALUE_W) ? i_value[(i < VALUE_W) ? i : 0]
                                       : i_value[VALUE_W-1];
        end
        for (int i = 0; i < VALUE_W; i++) begin
            front_ext[i] = rd_data[(i < DATA_WIDTH) ? i : DATA_WIDTH-1];
        end
        for (int i = 0; i < COUNT_W; i++) begin
            count_port[i] = (i < CW) ? r_count[(i < CW) ? i : 0] : 1'b0;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_value    = r_value;
        n_k        = r_k;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_tmp      = r_tmp;
        n_status   = r_status;
        n_ov       = r_ov;
        n_o_status = r_o_status;
        n_o_fv     = r_o_fv;
        n_o_fval   = r_o_fval;
        n_o_count  = r_o_count;
        wr_en      = 1'b0;
        wr_addr    = r_tail;
        wr_data    = r_value;
        rd_en      = 1'b0;
        rd_addr    = r_head;

        // result taken frees the register; a load below sets it again
        if (out_acc) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind   = i_kind;
                    n_value  = word_in;
                    n_k      = i_reverse_length;
                    n_status = ST_OK;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RD;
                case (r_kind)
                    KIND_ENQ: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            // append at the rear
                            wr_en   = 1'b1;
                            wr_addr = r_tail;
                            wr_data = r_value;
                            n_tail  = ring_inc(r_tail);
                            n_count = r_count + CW'(1);
                        end
                    end
                    KIND_DEQ: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_head  = ring_inc(r_head);
                            n_count = r_count - CW'(1);
                        end
                    end
                    KIND_REV: begin
                        if (k_ext > count_ext) begin
                            n_status = ST_TOO_LONG;
                        end else if (r_k > LEN_W'(1)) begin
                            // swap pairs from both ends inward
                            n_lo    = '0;
                            n_hi    = AW'(k_ext - KW'(1));
                            n_state = S_RA;
                        end
                    end
                    default: begin
                        // unused code: no change, state reported
                    end
                endcase
            end
            S_RA: begin
                rd_en   = 1'b1;
                rd_addr = addr_lo;
                n_state = S_RB;
            end
            S_RB: begin
                rd_en   = 1'b1;
                rd_addr = addr_hi;
                n_tmp   = rd_data;
                n_state = S_WA;
            end
            S_WA: begin
                wr_en   = 1'b1;
                wr_addr = addr_lo;
                wr_data = rd_data;
                n_state = S_WB;
            end
            S_WB: begin
                wr_en   = 1'b1;
                wr_addr = addr_hi;
                wr_data = r_tmp;
                n_lo    = r_lo + AW'(1);
                n_hi    = r_hi - AW'(1);
                // another pair while the ends have not met
                if (({1'b0, r_lo} + (AW+1)'(2)) < {1'b0, r_hi}) begin
                    n_state = S_RA;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_state = S_CAP;
            end
            S_CAP: begin
                // ram read data holds while the result register is busy
                if (!r_ov || out_acc) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_fv     = (r_count != '0);
                    n_o_fval   = (r_count != '0) ? front_ext : '0;
                    n_o_count  = count_port;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_k        <= n_k;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_tmp      <= n_tmp;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_fv     <= n_o_fv;
        r_o_fval   <= n_o_fval;
        r_o_count  <= n_o_count;
    end

    // ring store
    qrfk_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_front_valid = r_o_fv;
    assign o_front_value = r_o_fval;
    assign o_entry_count = r_o_count;

endmodule
